// File: rtl/core/dnsqx_pkg.sv
package dnsqx_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned MAX_LABELS   = 64;

  localparam logic [7:0] CHAR_DOT      = 8'h2E;
  localparam logic [7:0] CHAR_UNKNOWN  = 8'h3F;
  localparam logic [7:0] PTR_MASK      = 8'hC0;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LENGTH = 3'd1,
    PH_LABEL  = 3'd2,
    PH_STOP   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_POINTER = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    logic       done_res;
    logic [2:0] status;
  } out_beat_t;

  // Lowercase printable characters except space, replace everything else.
  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] r;
    if (c > 8'd32 && c < 8'd127) begin
      if (c >= 8'h41 && c <= 8'h5A) begin
        r = c + 8'd32;
      end else begin
        r = c;
      end
    end else begin
      r = CHAR_UNKNOWN;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/dns_qname_extractor.sv
// A result beat is registered in the output register, or in the skid register while out_data stalls.
// Throughput: one input beat per cycle while in_ready is high; each beat needs one small update of the parse state.
// A two-entry output buffer (output register plus skid register) keeps in_ready registered,
// so input continues for one more beat after the output side stalls.
// Reset (rst, synchronous, active high): parser returns to the header phase with all
// counters cleared and both output entries empty.
module dns_qname_extractor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dnsqx_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dnsqx_pkg::out_beat_t out_data
);

  // Parser state
  dnsqx_pkg::phase_t  phase, phase_next;
  logic [3:0]         header_count, header_count_next;
  logic [5:0]         label_remaining, label_remaining_next;
  logic [6:0]         labels_seen, labels_seen_next;
  dnsqx_pkg::status_t held_status, held_status_next;

  // Output buffer
  dnsqx_pkg::out_beat_t out_reg;
  dnsqx_pkg::out_beat_t skid_reg;
  logic                 out_full;
  logic                 skid_full;

  // Result of the current input beat
  dnsqx_pkg::out_beat_t res;
  logic                 res_valid;
  logic                 cv;
  logic [7:0]           ch;
  dnsqx_pkg::status_t   st;
  logic [3:0]           header_inc;
  logic [5:0]           label_dec;
  logic [6:0]           labels_inc;

  logic accept;
  logic pop;
  logic push;

  assign in_ready  = !skid_full;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_full;
  assign out_data  = out_reg;
  assign pop       = out_full && out_ready;

  assign header_inc = header_count + 4'd1;
  assign label_dec  = label_remaining - 6'd1;
  assign labels_inc = labels_seen + 7'd1;

  // Advance the parser by one payload byte.
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    label_remaining_next = label_remaining;
    labels_seen_next     = labels_seen;
    held_status_next     = held_status;
    cv                   = 1'b0;
    ch                   = 8'd0;
    st                   = dnsqx_pkg::ST_OK;
    unique case (phase)
      dnsqx_pkg::PH_HEADER: begin
        // Skip the fixed header; a payload ending here is too short.
        header_count_next = header_inc;
        if (header_inc >= 4'(dnsqx_pkg::HEADER_BYTES)) begin
          phase_next = dnsqx_pkg::PH_LENGTH;
        end
        st = dnsqx_pkg::ST_SHORT;
      end
      dnsqx_pkg::PH_LENGTH: begin
        priority if (in_data.data_byte == 8'd0) begin
          // Root label ends the name; no label at all means empty.
          held_status_next = (labels_seen == 7'd0) ? dnsqx_pkg::ST_EMPTY
                                                   : dnsqx_pkg::ST_OK;
          phase_next       = dnsqx_pkg::PH_STOP;
          st               = held_status_next;
        end else if ((in_data.data_byte & dnsqx_pkg::PTR_MASK) != 8'd0) begin
          // Compression pointer or reserved label type: stop with error.
          held_status_next = dnsqx_pkg::ST_POINTER;
          phase_next       = dnsqx_pkg::PH_STOP;
          st               = dnsqx_pkg::ST_POINTER;
        end else if (in_data.last_byte) begin
          // Length byte with no label bytes behind it.
          st = dnsqx_pkg::ST_TRUNC;
        end else begin
          // Open a new label; separate it from the previous one with a dot.
          if (labels_seen != 7'd0) begin
            cv = 1'b1;
            ch = dnsqx_pkg::CHAR_DOT;
          end
          label_remaining_next = in_data.data_byte[5:0];
          phase_next           = dnsqx_pkg::PH_LABEL;
        end
      end
      dnsqx_pkg::PH_LABEL: begin
        cv                   = 1'b1;
        ch                   = dnsqx_pkg::map_char(in_data.data_byte);
        label_remaining_next = label_dec;
        if (label_dec != 6'd0) begin
          st = dnsqx_pkg::ST_TRUNC;
        end else begin
          labels_seen_next = labels_inc;
          phase_next       = dnsqx_pkg::PH_LENGTH;
          st               = dnsqx_pkg::ST_OK;
          if (labels_inc >= 7'(dnsqx_pkg::MAX_LABELS)) begin
            // Label limit reached: stop cleanly.
            held_status_next = dnsqx_pkg::ST_OK;
            phase_next       = dnsqx_pkg::PH_STOP;
          end
        end
      end
      dnsqx_pkg::PH_STOP: begin
        st = held_status;
      end
      dnsqx_pkg::PH_DONE: begin
        // Drop every byte after the final one.
      end
      default: begin
      end
    endcase

    if (in_data.last_byte && phase != dnsqx_pkg::PH_DONE) begin
      phase_next = dnsqx_pkg::PH_DONE;
    end

    res_valid      = (phase != dnsqx_pkg::PH_DONE) && (in_data.last_byte || cv);
    res.name_char  = cv ? ch : 8'd0;
    res.char_valid = cv;
    res.done_res   = in_data.last_byte;
    res.status     = in_data.last_byte ? st : dnsqx_pkg::ST_OK;
  end

  assign push = accept && res_valid;

  // Hold the parser state; advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dnsqx_pkg::PH_HEADER;
      header_count    <= 4'd0;
      label_remaining <= 6'd0;
      labels_seen     <= 7'd0;
      held_status     <= dnsqx_pkg::ST_OK;
    end else if (accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      label_remaining <= label_remaining_next;
      labels_seen     <= labels_seen_next;
      held_status     <= held_status_next;
    end
  end

  // Output register plus skid register. The skid entry fills only when a
  // result arrives while the output register is stalled; drain it first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (skid_full) begin
        if (pop) begin
          skid_full <= 1'b0;
        end
      end else if (!out_full || pop) begin
        out_full <= push;
      end else if (push) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (!out_full || pop) begin
      if (push) begin
        out_reg <= res;
      end
    end else if (push) begin
      skid_reg <= res;
    end
  end

  // The skid entry is never occupied with an empty output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full)
    else $error("skid entry occupied while output register empty");

  // An accepted final byte always ends parsing.
  a_last_finishes: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.last_byte) |=> (phase == dnsqx_pkg::PH_DONE))
    else $error("final byte did not finish parsing");

  // Inside a label at least one byte is still owed.
  a_label_owed: assert property (@(posedge clk) disable iff (rst)
    (phase == dnsqx_pkg::PH_LABEL) |-> (label_remaining != 6'd0))
    else $error("label phase with nothing owed");

  // A non-final result always carries a character.
  a_result_has_content: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_reg.done_res) |-> out_reg.char_valid)
    else $error("empty non-final result");

  // Label count never passes the limit.
  a_label_limit: assert property (@(posedge clk) disable iff (rst)
    labels_seen <= 7'(dnsqx_pkg::MAX_LABELS))
    else $error("label count beyond limit");

endmodule

// File: dv/tb.sv
module tb;

  // Ways the single payload of a run can end. Once the final byte has been
  // taken the block ignores everything until reset, and reset comes only once,
  // so each run carries one long payload and picks one of these endings.
  typedef enum int {
    END_ZERO_LAST,
    END_ZERO_TAIL,
    END_POINTER,
    END_TRUNC_LEN,
    END_TRUNC_LABEL,
    END_AFTER_LABEL,
    END_LABEL_LIMIT
  } ending_t;

  localparam int CYCLE_LIMIT = 100000;
  localparam int MAIN_BYTES  = 1650;
  localparam int MAIN_LABELS = 56;
  localparam int SETTLE      = 20;
  localparam int SHOW_LIMIT  = 10;

  // Tracks the parse of the query name and holds the name beats still owed.
  class qname_tracker;
    logic [3:0]           hdr_cnt;
    dnsqx_pkg::phase_t    ph;
    logic [5:0]           lbl_left;
    logic [6:0]           lbl_done;
    dnsqx_pkg::status_t   kept;
    dnsqx_pkg::out_beat_t owed_beats[$];
    int                   mismatches;

    function new();
      hdr_cnt    = '0;
      ph         = dnsqx_pkg::PH_HEADER;
      lbl_left   = '0;
      lbl_done   = '0;
      kept       = dnsqx_pkg::ST_OK;
      mismatches = 0;
    endfunction

    function logic [7:0] fold_char(logic [7:0] c);
      if (c <= 8'd32 || c >= 8'd127) return dnsqx_pkg::CHAR_UNKNOWN;
      if (c >= "A" && c <= "Z") return c + 8'd32;
      return c;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= SHOW_LIMIT) $display("%0t: %s", $time, what);
    endfunction

    // Advance the parse by one accepted byte; queue the beat it causes.
    function void note_byte(dnsqx_pkg::in_beat_t beat);
      logic [7:0]           b;
      logic                 cv;
      logic [7:0]           ch;
      dnsqx_pkg::status_t   st;
      dnsqx_pkg::out_beat_t r;
      b  = beat.data_byte;
      cv = 1'b0;
      ch = 8'h00;
      st = dnsqx_pkg::ST_OK;
      case (ph)
        dnsqx_pkg::PH_HEADER: begin
          hdr_cnt = hdr_cnt + 4'd1;
          if (hdr_cnt >= dnsqx_pkg::HEADER_BYTES) ph = dnsqx_pkg::PH_LENGTH;
          st = dnsqx_pkg::ST_SHORT;
        end
        dnsqx_pkg::PH_LENGTH: begin
          if (b == 8'h00) begin
            kept = (lbl_done == 0) ? dnsqx_pkg::ST_EMPTY : dnsqx_pkg::ST_OK;
            ph   = dnsqx_pkg::PH_STOP;
            st   = kept;
          end else if ((b & dnsqx_pkg::PTR_MASK) != 8'h00) begin
            kept = dnsqx_pkg::ST_POINTER;
            ph   = dnsqx_pkg::PH_STOP;
            st   = kept;
          end else if (beat.last_byte) begin
            // Length byte as final byte: no dot for it.
            st = dnsqx_pkg::ST_TRUNC;
          end else begin
            if (lbl_done != 0) begin
              cv = 1'b1;
              ch = dnsqx_pkg::CHAR_DOT;
            end
            lbl_left = b[5:0];
            ph       = dnsqx_pkg::PH_LABEL;
          end
        end
        dnsqx_pkg::PH_LABEL: begin
          cv       = 1'b1;
          ch       = fold_char(b);
          lbl_left = lbl_left - 6'd1;
          if (lbl_left != 0) begin
            st = dnsqx_pkg::ST_TRUNC;
          end else begin
            lbl_done = lbl_done + 7'd1;
            ph       = dnsqx_pkg::PH_LENGTH;
            st       = dnsqx_pkg::ST_OK;
            if (lbl_done >= dnsqx_pkg::MAX_LABELS) begin
              kept = dnsqx_pkg::ST_OK;
              ph   = dnsqx_pkg::PH_STOP;
            end
          end
        end
        dnsqx_pkg::PH_STOP: begin
          st = kept;
        end
        default: return;
      endcase
      r.name_char  = cv ? ch : 8'h00;
      r.char_valid = cv;
      r.done_res   = beat.last_byte;
      r.status     = beat.last_byte ? st : dnsqx_pkg::ST_OK;
      if (beat.last_byte) ph = dnsqx_pkg::PH_DONE;
      if (beat.last_byte || cv) owed_beats.push_back(r);
    endfunction

    // Compare one accepted result beat with the oldest owed one.
    function void check_beat(dnsqx_pkg::out_beat_t got);
      dnsqx_pkg::out_beat_t want;
      if (owed_beats.size() == 0) begin
        flag($sformatf("unexpected beat: char %h valid %b done %b status %0d",
                       got.name_char, got.char_valid, got.done_res, got.status));
        return;
      end
      want = owed_beats.pop_front();
      if (got.name_char !== want.name_char || got.char_valid !== want.char_valid ||
          got.done_res !== want.done_res || got.status !== want.status) begin
        flag($sformatf({"beat mismatch: expected char %h valid %b done %b status %0d,",
                        " got char %h valid %b done %b status %0d"},
                       want.name_char, want.char_valid, want.done_res, want.status,
                       got.name_char, got.char_valid, got.done_res, got.status));
      end
    endfunction

    function void close_out();
      if (owed_beats.size() != 0) begin
        flag($sformatf("%0d beats never arrived", owed_beats.size()));
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  dnsqx_pkg::in_beat_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dnsqx_pkg::out_beat_t out_data;

  qname_tracker        tracker;
  dnsqx_pkg::in_beat_t dns_bytes[$];
  int                  labels_built = 0;
  int                  stall_pct = 0;
  int                  cycle_count = 0;

  dns_qname_extractor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Observe both channels at the edge; inputs are noted before results so a
  // beat can never be checked ahead of the byte that caused it.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_byte(in_data);
      if (out_valid && out_ready) tracker.check_beat(out_data);
    end
  end

  function automatic logic [7:0] label_char();
    // Lean on uppercase now and then so folding gets plenty of work.
    if ($urandom_range(3) == 0) return 8'($urandom_range(8'h41, 8'h5A));
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_byte(logic [7:0] b, logic last);
    dnsqx_pkg::in_beat_t beat;
    beat.data_byte = b;
    beat.last_byte = last;
    dns_bytes.push_back(beat);
  endfunction

  // Append a full label: length byte then its characters, none final.
  function automatic void add_label(int len);
    add_byte(8'(len), 1'b0);
    for (int j = 0; j < len; j++) add_byte(label_char(), 1'b0);
    labels_built++;
  endfunction

  // Append n bytes of noise, the last of them final.
  function automatic void add_tail(int n);
    for (int j = 0; j < n; j++) add_byte(8'($urandom_range(255)), j == n - 1);
  endfunction

  task automatic send_beat(input dnsqx_pkg::in_beat_t beat, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender off until every owed beat has come back.
  task automatic wait_for_names();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_beats.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] probe[14];
    int         idle_tab[4];
    int         stall_tab[4];
    int         main_len;
    int         cur_ph;
    int         ph_idx;
    int         idle_pct;
    int         len;
    int         k;
    ending_t    ending;

    probe     = '{8'h00, 8'h20, 8'h21, 8'h40, 8'h41, 8'h5A, 8'h5B,
                  8'h60, 8'h61, 8'h7A, 8'h7E, 8'h7F, 8'h80, 8'hFF};
    idle_tab  = '{0, 59, 0, 34};
    stall_tab = '{0, 0, 59, 34};

    tracker = new();

    // Header: extremes first, pointer-like and zero bytes included.
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hC0, 1'b0);
    for (int i = 3; i < dnsqx_pkg::HEADER_BYTES; i++) begin
      add_byte(8'($urandom_range(255)), 1'b0);
    end

    // First label walks the edges of the printable range and case folding.
    add_byte(8'd14, 1'b0);
    foreach (probe[i]) add_byte(probe[i], 1'b0);
    labels_built = 1;
    add_label(63);
    add_label(1);

    while (dns_bytes.size() < MAIN_BYTES && labels_built < MAIN_LABELS) begin
      add_label($urandom_range(1, 63));
    end

    ending = ending_t'($urandom_range(END_ZERO_LAST, END_LABEL_LIMIT));
    case (ending)
      END_ZERO_LAST: begin
        add_byte(8'h00, 1'b1);
      end
      END_ZERO_TAIL: begin
        add_byte(8'h00, 1'b0);
        add_tail($urandom_range(1, 12));
      end
      END_POINTER: begin
        k = $urandom_range(0, 12);
        add_byte(8'($urandom_range(8'h40, 8'hFF)), k == 0);
        if (k != 0) add_tail(k);
      end
      END_TRUNC_LEN: begin
        add_byte(8'($urandom_range(1, 63)), 1'b1);
      end
      END_TRUNC_LABEL: begin
        len = $urandom_range(2, 63);
        k   = $urandom_range(1, len - 1);
        add_byte(8'(len), 1'b0);
        for (int j = 0; j < k; j++) add_byte(label_char(), j == k - 1);
      end
      END_AFTER_LABEL: begin
        dns_bytes[dns_bytes.size() - 1].last_byte = 1'b1;
      end
      default: begin
        // Reach the label limit with short labels, then noise while stopped.
        while (labels_built < dnsqx_pkg::MAX_LABELS) add_label($urandom_range(1, 8));
        add_tail($urandom_range(1, 15));
      end
    endcase
    main_len = dns_bytes.size();

    // Bytes after the final one must be ignored.
    repeat (SETTLE) add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    cur_ph   = 0;
    idle_pct = idle_tab[0];
    for (int i = 0; i < dns_bytes.size(); i++) begin
      ph_idx = (i < main_len) ? (i * 4) / main_len : 3;
      if (ph_idx != cur_ph) begin
        wait_for_names();
        cur_ph    = ph_idx;
        idle_pct  = idle_tab[cur_ph];
        stall_pct <= stall_tab[cur_ph];
      end
      send_beat(dns_bytes[i], idle_pct);
    end

    wait_for_names();
    repeat (SETTLE) @(posedge clk);
    tracker.close_out();

    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
